// ----- src/lcpm_pkg.sv -----
// shared types and constants for the led color pulse/morph animator
// no dependencies; imported by the channel interfaces, the ramp lane and the top level
package lcpm_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 32;
  localparam int PERIOD_W  = 18;   // 2*span + start hold + end hold
  localparam int TOTAL_W   = 26;   // period * repeat count
  localparam int PROD_W    = 24;   // ramp offset * channel difference

  localparam logic [15:0] DEFAULT_TRANSITION = 16'd200;
  localparam logic [7:0]  DEFAULT_REPEATS    = 8'd5;

  typedef enum logic [1:0] {
    MODE_INSTANT = 2'd0,
    MODE_MORPH   = 2'd1,
    MODE_PULSE   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFECT_MODE,
    REG_TRANSITION_MS,
    REG_START_HOLD_MS,
    REG_END_HOLD_MS,
    REG_REPEAT_COUNT,
    REG_START_COLOR,
    REG_END_COLOR,
    REG_REST_COLOR
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_CHECK,
    ST_MOD,
    ST_PHASE,
    ST_LAUNCH,
    ST_RAMP,
    ST_FINISH
  } lcpm_state_t;

  typedef struct packed {
    logic        go;
    logic        down;
    logic [15:0] offset;
    logic [15:0] span;
  } lcpm_ramp_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } lcpm_lane_st_t;

endpackage

// ----- src/lcpm_ifs.sv -----
// valid/ready channel interfaces: input items, result items, register writes
// depends on lcpm_pkg
interface lcpm_item_if;
  import lcpm_pkg::*;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] tick_count;
  modport source (output valid, output restart, output tick_count, input ready);
  modport sink   (input valid, input restart, input tick_count, output ready);
endinterface

interface lcpm_result_if;
  import lcpm_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] brightness;
  logic       changed;
  logic       active;
  modport source (output valid, output red, output green, output blue, output brightness,
                  output changed, output active, input ready);
  modport sink   (input valid, input red, input green, input blue, input brightness,
                  input changed, input active, output ready);
endinterface

interface lcpm_cfg_if;
  import lcpm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/lcpm_ramp.sv -----
// one color channel of the ramp: start + q up, end - q down, q = trunc(offset*(end-start)/span)
// one quotient bit per cycle; depends on lcpm_pkg
module lcpm_ramp (
  input  logic                     clk,
  input  logic                     rst,
  input  lcpm_pkg::lcpm_ramp_req_t req,
  input  logic [7:0]               start_byte,
  input  logic [7:0]               end_byte,
  output lcpm_pkg::lcpm_lane_st_t  status
);
  import lcpm_pkg::*;

  logic [8:0]        diff;
  logic [7:0]        mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-2:0] dsr;
  logic [7:0]        quot;
  logic [2:0]        step;
  logic              busy;
  logic              done;
  logic              neg;
  logic              down;
  logic [7:0]        s_r;
  logic [7:0]        e_r;
  logic              fits;

  always_comb begin
    diff = {1'b0, end_byte} - {1'b0, start_byte};
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
    prod = {8'b0, req.offset} * {16'b0, mag};
    fits = ({1'b0, dsr} <= rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (req.go) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem  <= prod;
      dsr  <= {req.span, 7'b0};
      quot <= '0;
      neg  <= diff[8];
      down <= req.down;
      s_r  <= start_byte;
      e_r  <= end_byte;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - {1'b0, dsr};
      end
      quot <= {quot[6:0], fits};
      dsr  <= dsr >> 1;
    end
  end

  // sign of the difference folds into add or subtract, 8-bit wrap
  always_comb begin
    status.done = done;
    if (down) begin
      status.value = neg ? (e_r + quot) : (e_r - quot);
    end else begin
      status.value = neg ? (s_r - quot) : (s_r + quot);
    end
  end

endmodule

// ----- src/led_color_pulse_morph_animator.sv -----
// top level of the led color pulse/morph animator: registers, sequencer, period remainder
// depends on lcpm_pkg, lcpm_ifs and lcpm_ramp
// One item is taken at a time. An item that only restarts, idles or ends an effect goes from
// ST_TOTAL and ST_CHECK to ST_FINISH; a morph ramp item also passes ST_LAUNCH and ST_RAMP, a
// pulse item first finds the period remainder in ST_MOD and its phase in ST_PHASE and ramps only
// in a ramp phase, the four channel lanes each finding one quotient bit per cycle. The result
// sits in an output register, so the next item is accepted as soon as the sequencer is back to
// idle, even while that result is still waiting; a new result waits only if the previous one has
// not been taken. Register writes are always accepted and must only happen between items.
module led_color_pulse_morph_animator #(
  parameter int ELAPSED_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  lcpm_item_if.sink     items,
  lcpm_result_if.source results,
  lcpm_cfg_if.sink      cfg
);
  import lcpm_pkg::*;

  localparam int EW1   = ELAPSED_WIDTH + 1;
  localparam int CMP_W = (ELAPSED_WIDTH > TOTAL_W) ? ELAPSED_WIDTH : TOTAL_W;

  // configuration
  logic [1:0]         effect_mode;
  logic [15:0]        transition_ms;
  logic [15:0]        start_hold_ms;
  logic [15:0]        end_hold_ms;
  logic [7:0]         repeat_count;
  logic [COLOR_W-1:0] start_color;
  logic [COLOR_W-1:0] end_color;
  logic [COLOR_W-1:0] rest_color;

  // derived from configuration
  logic [15:0]         span;
  logic [7:0]          reps;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] bnd_a;
  logic [PERIOD_W-1:0] bnd_b;
  logic [PERIOD_W-1:0] bnd_c;
  logic [PERIOD_W-1:0] bnd_d;

  // animation state
  logic [ELAPSED_WIDTH-1:0] elapsed;
  logic                     running;
  logic [COLOR_W-1:0]       shown;
  logic [COLOR_W-1:0]       color_next;

  // work registers
  lcpm_state_t         state;
  lcpm_state_t         state_next;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  rem;
  logic [TOTAL_W-2:0]  pdiv;
  logic [2:0]          mod_step;
  logic [15:0]         ramp_off;
  logic                ramp_down;
  logic                out_valid;

  logic                accept;
  logic                out_wr;
  logic [EW1-1:0]      elapsed_sum;
  logic [CMP_W-1:0]    elapsed_x;
  logic                morph_done;
  logic                pulse_done;
  logic                mod_fits;
  logic [PERIOD_W-1:0] phase;
  logic                in_a;
  logic                in_b;
  logic                in_c;
  logic                in_d;
  logic                all_done;

  lcpm_ramp_req_t ramp_req;
  lcpm_lane_st_t  lane_st [4];

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode   <= MODE_INSTANT;
      transition_ms <= DEFAULT_TRANSITION;
      start_hold_ms <= '0;
      end_hold_ms   <= '0;
      repeat_count  <= DEFAULT_REPEATS;
      start_color   <= '0;
      end_color     <= '0;
      rest_color    <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_EFFECT_MODE:   effect_mode   <= cfg.data[1:0];
        REG_TRANSITION_MS: transition_ms <= cfg.data[15:0];
        REG_START_HOLD_MS: start_hold_ms <= cfg.data[15:0];
        REG_END_HOLD_MS:   end_hold_ms   <= cfg.data[15:0];
        REG_REPEAT_COUNT:  repeat_count  <= cfg.data[7:0];
        REG_START_COLOR:   start_color   <= cfg.data;
        REG_END_COLOR:     end_color     <= cfg.data;
        REG_REST_COLOR:    rest_color    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign span = (transition_ms != '0) ? transition_ms : DEFAULT_TRANSITION;
  assign reps = (repeat_count != '0) ? repeat_count : DEFAULT_REPEATS;

  // period and the bnd_a to bnd_d chain are registered; they settle long before they are used
  always_ff @(posedge clk) begin
    period <= {1'b0, span, 1'b0} + {2'b0, start_hold_ms} + {2'b0, end_hold_ms};
    bnd_a  <= {3'b0, start_hold_ms[15:1]};
    bnd_b  <= bnd_a + {2'b0, span};
    bnd_c  <= bnd_b + {2'b0, end_hold_ms};
    bnd_d  <= bnd_c + {2'b0, span};
  end

  // datapath compares
  always_comb begin
    accept      = items.valid && items.ready;
    elapsed_sum = {1'b0, elapsed} + EW1'(items.tick_count);
    elapsed_x   = CMP_W'(elapsed);
    morph_done  = elapsed_x >= CMP_W'(span);
    pulse_done  = elapsed_x >= CMP_W'(total);
    mod_fits    = {1'b0, pdiv} <= rem;
    phase       = rem[PERIOD_W-1:0];
    in_a        = phase < bnd_a;
    in_b        = phase < bnd_b;
    in_c        = phase < bnd_c;
    in_d        = phase < bnd_d;
    all_done    = 1'b1;
    for (int k = 0; k < 4; k++) begin
      all_done = all_done & lane_st[k].done;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_TOTAL;
      ST_TOTAL:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (!running) begin
          state_next = ST_FINISH;
        end else begin
          case (effect_mode)
            MODE_MORPH: state_next = morph_done ? ST_FINISH : ST_LAUNCH;
            MODE_PULSE: state_next = pulse_done ? ST_FINISH : ST_MOD;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_MOD:    if (mod_step == 3'd7) state_next = ST_PHASE;
      ST_PHASE: begin
        if ((!in_a && in_b) || (!in_c && in_d)) begin
          state_next = ST_LAUNCH;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_LAUNCH: state_next = ST_RAMP;
      ST_RAMP:   if (all_done) state_next = ST_FINISH;
      ST_FINISH: if (out_wr) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready     = (state == ST_IDLE);
    out_wr          = (state == ST_FINISH) && (!out_valid || results.ready);
    ramp_req.go     = (state == ST_LAUNCH);
    ramp_req.down   = ramp_down;
    ramp_req.offset = ramp_off;
    ramp_req.span   = span;
  end

  // animation state and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      running <= 1'b0;
      shown   <= '0;
    end else begin
      if (accept) begin
        if (items.restart) begin
          elapsed <= '0;
          running <= (effect_mode == MODE_MORPH) || (effect_mode == MODE_PULSE);
        end else if (running) begin
          elapsed <= elapsed_sum[ELAPSED_WIDTH] ? '1 : elapsed_sum[ELAPSED_WIDTH-1:0];
        end
      end
      if (state == ST_CHECK && running) begin
        case (effect_mode)
          MODE_MORPH: if (morph_done) running <= 1'b0;
          MODE_PULSE: if (pulse_done) running <= 1'b0;
          default:    running <= 1'b0;
        endcase
      end
      if (out_wr) begin
        shown <= color_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          color_next <= (items.restart && effect_mode == MODE_INSTANT) ? end_color : shown;
        end
      end
      ST_TOTAL: total <= TOTAL_W'({8'b0, period} * {18'b0, reps});
      ST_CHECK: begin
        if (running && effect_mode == MODE_MORPH) begin
          if (morph_done) begin
            color_next <= end_color;
          end
          ramp_off  <= elapsed[15:0];
          ramp_down <= 1'b0;
        end else if (running && effect_mode == MODE_PULSE) begin
          if (pulse_done) begin
            color_next <= rest_color;
          end
          // elapsed is below total here, so the quotient fits in 8 bits
          rem      <= TOTAL_W'(elapsed);
          pdiv     <= {period, 7'b0};
          mod_step <= '0;
        end
      end
      ST_MOD: begin
        if (mod_fits) begin
          rem <= rem - {1'b0, pdiv};
        end
        pdiv     <= pdiv >> 1;
        mod_step <= mod_step + 3'd1;
      end
      ST_PHASE: begin
        if (in_a) begin
          color_next <= start_color;
        end else if (in_b) begin
          ramp_off  <= 16'(phase - bnd_a);
          ramp_down <= 1'b0;
        end else if (in_c) begin
          color_next <= end_color;
        end else if (in_d) begin
          ramp_off  <= 16'(phase - bnd_c);
          ramp_down <= 1'b1;
        end else begin
          color_next <= start_color;
        end
      end
      ST_RAMP: begin
        if (all_done) begin
          color_next <= {lane_st[3].value, lane_st[2].value, lane_st[1].value, lane_st[0].value};
        end
      end
      default: ;
    endcase
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    lcpm_ramp u_ramp (
      .clk        (clk),
      .rst        (rst),
      .req        (ramp_req),
      .start_byte (start_color[8*k +: 8]),
      .end_byte   (end_color[8*k +: 8]),
      .status     (lane_st[k])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_wr) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      results.red        <= color_next[7:0];
      results.green      <= color_next[15:8];
      results.blue       <= color_next[23:16];
      results.brightness <= color_next[31:24];
      results.changed    <= (color_next != shown);
      results.active     <= running;
    end
  end

  assign results.valid = out_valid;

  a_restart_zeroes: assert property (@(posedge clk) disable iff (rst)
    accept && items.restart |=> elapsed == '0)
    else $error("restart beat did not clear elapsed time");

  a_mod_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_MOD |-> rem < {pdiv, 1'b0})
    else $error("period remainder out of range for its step");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PHASE |-> rem < TOTAL_W'(period))
    else $error("phase not below period");

  a_shown_tracks: assert property (@(posedge clk) disable iff (rst)
    out_wr |=> shown == {results.brightness, results.blue, results.green, results.red})
    else $error("shown color differs from the result beat");

endmodule

// ----- tb/testbench.sv -----
// testbench for the led color pulse/morph animator: directed then random items on the item channel,
// register writes between phases, every result checked against an in-bench color predictor
// depends on lcpm_pkg, lcpm_ifs and the led_color_pulse_morph_animator top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcpm_pkg::*;

  localparam int EW          = 32;
  localparam int ITEM_TARGET = 1450;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 30;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
    logic       changed;
    logic       active;
  } frame_t;

  // predictor of the animator plus the queue of frames it still expects
  class color_scoreboard;
    logic [1:0]        mode;
    logic [15:0]       trans_ms;
    logic [15:0]       shold_ms;
    logic [15:0]       ehold_ms;
    logic [7:0]        reps_cfg;
    logic [31:0]       c_start;
    logic [31:0]       c_end;
    logic [31:0]       c_rest;
    longint unsigned   elapsed;
    bit                running;
    logic [31:0]       shown;
    frame_t            frame_q[$];
    int                errors;
    int                reported;

    function new();
      mode     = MODE_INSTANT;
      trans_ms = DEFAULT_TRANSITION;
      shold_ms = '0;
      ehold_ms = '0;
      reps_cfg = DEFAULT_REPEATS;
      c_start  = '0;
      c_end    = '0;
      c_rest   = '0;
      elapsed  = 0;
      running  = 1'b0;
      shown    = '0;
      errors   = 0;
      reported = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_EFFECT_MODE:   mode = d[1:0];
        REG_TRANSITION_MS: trans_ms = d[15:0];
        REG_START_HOLD_MS: shold_ms = d[15:0];
        REG_END_HOLD_MS:   ehold_ms = d[15:0];
        REG_REPEAT_COUNT:  reps_cfg = d[7:0];
        REG_START_COLOR:   c_start = d;
        REG_END_COLOR:     c_end = d;
        REG_REST_COLOR:    c_rest = d;
        default: ;
      endcase
    endfunction

    // per byte lane: start + q going up, end - q going down, q truncated toward zero
    function logic [31:0] ramp_color(longint off, longint span, bit down);
      logic [31:0] res;
      longint      s;
      longint      e;
      longint      q;
      longint      v;
      res = '0;
      for (int k = 0; k < 4; k++) begin
        s = longint'(c_start[8*k +: 8]);
        e = longint'(c_end[8*k +: 8]);
        q = (off * (e - s)) / span;
        v = down ? (e - q) : (s + q);
        res[8*k +: 8] = v[7:0];
      end
      return res;
    endfunction

    function void note_item(bit rs, logic [7:0] tk);
      longint unsigned emax;
      longint unsigned span;
      longint unsigned reps;
      longint unsigned period;
      longint unsigned total;
      longint unsigned p;
      longint unsigned a;
      longint unsigned b;
      longint unsigned c;
      longint unsigned d;
      logic [31:0]     prev;
      logic [31:0]     nxt;
      frame_t          f;
      emax = (64'd1 << EW) - 1;
      span = (trans_ms != 0) ? trans_ms : DEFAULT_TRANSITION;
      reps = (reps_cfg != 0) ? reps_cfg : DEFAULT_REPEATS;
      prev = shown;
      nxt  = shown;
      if (rs) begin
        elapsed = 0;
        running = (mode == MODE_MORPH) || (mode == MODE_PULSE);
        if (mode == MODE_INSTANT) nxt = c_end;
      end else if (running) begin
        elapsed = (emax - elapsed < tk) ? emax : elapsed + tk;
      end

      if (running && mode == MODE_MORPH) begin
        if (elapsed >= span) begin
          nxt = c_end;
          running = 1'b0;
        end else begin
          nxt = ramp_color(elapsed, span, 1'b0);
        end
      end else if (running && mode == MODE_PULSE) begin
        period = 2 * span + shold_ms + ehold_ms;
        total  = period * reps;
        if (elapsed >= total) begin
          nxt = c_rest;
          running = 1'b0;
        end else begin
          p = elapsed % period;
          a = shold_ms / 2;
          b = a + span;
          c = b + ehold_ms;
          d = c + span;
          if (p < a) nxt = c_start;
          else if (p < b) nxt = ramp_color(p - a, span, 1'b0);
          else if (p < c) nxt = c_end;
          else if (p < d) nxt = ramp_color(p - c, span, 1'b1);
          else nxt = c_start;
        end
      end else if (running) begin
        running = 1'b0;
      end

      shown        = nxt;
      f.red        = nxt[7:0];
      f.green      = nxt[15:8];
      f.blue       = nxt[23:16];
      f.brightness = nxt[31:24];
      f.changed    = (nxt != prev);
      f.active     = running;
      frame_q.push_back(f);
    endfunction

    function void check_result(frame_t got);
      frame_t want;
      if (frame_q.size() == 0) begin
        errors++;
        if (reported < 100) begin
          reported++;
          $display("%0t: unexpected result beat, actual %h", $time, got);
        end
        return;
      end
      want = frame_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.brightness !== want.brightness || got.changed !== want.changed ||
          got.active !== want.active) begin
        errors++;
        if (reported < 100) begin
          reported++;
          $display("%0t: result mismatch, expected r=%h g=%h b=%h br=%h chg=%b act=%b",
                   $time, want.red, want.green, want.blue, want.brightness,
                   want.changed, want.active);
          $display("%0t:                  actual   r=%h g=%h b=%h br=%h chg=%b act=%b",
                   $time, got.red, got.green, got.blue, got.brightness,
                   got.changed, got.active);
        end
      end
    endfunction

    function int pending();
      return frame_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lcpm_item_if   item_ch();
  lcpm_result_if result_ch();
  lcpm_cfg_if    cfg_ch();

  led_color_pulse_morph_animator #(.ELAPSED_WIDTH(EW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  color_scoreboard sb = new();
  int items_sent = 0;
  int src_idle   = 27;
  int snk_idle   = 69;
  int quiet      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, checked at the rising edge
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  initial begin
    frame_t got;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.red        = result_ch.red;
        got.green      = result_ch.green;
        got.blue       = result_ch.blue;
        got.brightness = result_ch.brightness;
        got.changed    = result_ch.changed;
        got.active     = result_ch.active;
        sb.check_result(got);
      end
    end
  end

  // watchdog: any beat on any channel clears the count
  initial begin
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic send_item(input bit rs, input logic [7:0] tk);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.restart    <= rs;
    item_ch.tick_count <= tk;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(rs, tk);
    items_sent++;
    if (items_sent >= 2 * ITEM_TARGET / 3) begin
      src_idle = 0;
      snk_idle = 0;
    end else if (items_sent >= ITEM_TARGET / 3) begin
      src_idle = 69;
      snk_idle = 27;
    end
  endtask

  // drop valid, let every expected frame drain, then give the sequencer time to settle
  task automatic drain_items();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_ticks();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    else if (r < 20) return 8'd255;
    else if (r < 50) return 8'($urandom_range(4, 1));
    else return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] random_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    else if (r < 14) return 16'hFFFF;
    else if (r < 64) return 16'($urandom_range(20, 1));
    else if (r < 94) return 16'($urandom_range(400, 1));
    else return 16'($urandom());
  endfunction

  function automatic logic [15:0] random_hold();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 16'd0;
    else if (r < 80) return 16'($urandom_range(20, 1));
    else if (r < 85) return 16'hFFFF;
    else if (r < 95) return 16'($urandom_range(300));
    else return 16'($urandom());
  endfunction

  function automatic logic [31:0] random_color();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 32'h0000_0000;
    else if (r < 16) return 32'hFFFF_FFFF;
    else return $urandom();
  endfunction

  task automatic randomize_config();
    int unsigned r;
    if ($urandom_range(1)) begin
      r = $urandom_range(99);
      if (r < 10) cfg_write(REG_EFFECT_MODE, 32'd3);
      else if (r < 25) cfg_write(REG_EFFECT_MODE, MODE_INSTANT);
      else if (r < 60) cfg_write(REG_EFFECT_MODE, MODE_MORPH);
      else cfg_write(REG_EFFECT_MODE, MODE_PULSE);
    end
    if ($urandom_range(1)) cfg_write(REG_TRANSITION_MS, {16'($urandom()), random_span()});
    if ($urandom_range(1)) cfg_write(REG_START_HOLD_MS, {16'h0, random_hold()});
    if ($urandom_range(1)) cfg_write(REG_END_HOLD_MS, {16'h0, random_hold()});
    if ($urandom_range(1)) begin
      r = $urandom_range(99);
      if (r < 10) cfg_write(REG_REPEAT_COUNT, 32'd0);
      else if (r < 70) cfg_write(REG_REPEAT_COUNT, 32'($urandom_range(4, 1)));
      else if (r < 80) cfg_write(REG_REPEAT_COUNT, 32'd255);
      else cfg_write(REG_REPEAT_COUNT, 32'($urandom_range(255)));
    end
    if ($urandom_range(1)) cfg_write(REG_START_COLOR, random_color());
    if ($urandom_range(1)) cfg_write(REG_END_COLOR, random_color());
    if ($urandom_range(1)) cfg_write(REG_REST_COLOR, random_color());
    cfg_release();
  endtask

  initial begin
    int unsigned n;
    int          leftover;
    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.restart    = 1'b0;
    item_ch.tick_count = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_EFFECT_MODE;
    cfg_ch.data        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle before any effect: color held, nothing active
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd255);

    // instant mode, then a repeat restart that changes nothing
    drain_items();
    cfg_write(REG_END_COLOR, 32'hFFFF_FFFF);
    cfg_release();
    send_item(1'b1, 8'd0);
    send_item(1'b1, 8'd17);

    // morph with the default span, lanes rising and falling; restart ignores its ticks
    drain_items();
    cfg_write(REG_EFFECT_MODE, MODE_MORPH);
    cfg_write(REG_START_COLOR, 32'h10F0_00FF);
    cfg_write(REG_END_COLOR, 32'hF010_0000);
    cfg_write(REG_TRANSITION_MS, 32'd0);
    cfg_release();
    send_item(1'b1, 8'd255);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'd99);
    send_item(1'b0, 8'd99);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd3);

    // short pulse with an odd start hold, two repeats, then rest color
    drain_items();
    cfg_write(REG_EFFECT_MODE, MODE_PULSE);
    cfg_write(REG_TRANSITION_MS, 32'd3);
    cfg_write(REG_START_HOLD_MS, 32'd5);
    cfg_write(REG_END_HOLD_MS, 32'd2);
    cfg_write(REG_REPEAT_COUNT, 32'd2);
    cfg_write(REG_REST_COLOR, 32'h5A5A_A5A5);
    cfg_release();
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'd2);
    send_item(1'b0, 8'd2);
    send_item(1'b0, 8'd3);
    send_item(1'b0, 8'd255);

    // unused mode written mid-pulse: restart stops it and keeps the color
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd4);
    drain_items();
    cfg_write(REG_EFFECT_MODE, 32'd3);
    cfg_release();
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd9);

    // largest span, holds and repeat count
    drain_items();
    cfg_write(REG_EFFECT_MODE, MODE_MORPH);
    cfg_write(REG_TRANSITION_MS, 32'hFFFF);
    cfg_write(REG_START_COLOR, 32'h0000_0000);
    cfg_write(REG_END_COLOR, 32'hFFFF_FFFF);
    cfg_release();
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd255);
    drain_items();
    cfg_write(REG_EFFECT_MODE, MODE_PULSE);
    cfg_write(REG_REPEAT_COUNT, 32'd255);
    cfg_write(REG_START_HOLD_MS, 32'hFFFF);
    cfg_write(REG_END_HOLD_MS, 32'hFFFF);
    cfg_release();
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd255);

    // random phases: mostly a restart followed by a run of ticks, some noise
    while (items_sent < ITEM_TARGET) begin
      drain_items();
      randomize_config();
      if ($urandom_range(99) < 85) begin
        send_item(1'b1, random_ticks());
        n = $urandom_range(40, 5);
        repeat (n) send_item($urandom_range(99) < 4, random_ticks());
      end else begin
        n = $urandom_range(12, 3);
        repeat (n) send_item(1'($urandom_range(1)), random_ticks());
      end
    end

    drain_items();
    repeat (50) @(negedge clk);
    leftover = sb.pending();
    if (leftover != 0)
      $display("%0t: %0d expected results never arrived", $time, leftover);
    if (sb.errors == 0 && leftover == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
